FILE: design/bankers_safety_and_request_top_assert.svh
// Assertion macros for the banker's safety and request block.
// Used by bankers_safety_and_request_top; expects i_clk and i_rst_n in scope.
`ifndef BANKERS_SAFETY_AND_REQUEST_TOP_ASSERT_SVH
`define BANKERS_SAFETY_AND_REQUEST_TOP_ASSERT_SVH
`ifndef SYNTH
`define BSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BSR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BSR_ASSERT(lbl, prop, msg)
`define BSR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: design/bsr_pkg.sv
// Shared types and constants for the banker's safety and request block.
// No dependencies; imported by the interfaces and by every module except bsr_ram.
package bsr_pkg;

    localparam int UNIT_W     = 8;
    localparam int OP_W       = 3;
    localparam int PROC_W     = 3;
    localparam int RES_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int SEQ_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int NUM_PROC_W = 4;
    localparam int NUM_RES_W  = 3;
    localparam int REQ_FIELDS = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ALLOC = 3'd0,
        OP_LOAD_CLAIM = 3'd1,
        OP_LOAD_AVAIL = 3'd2,
        OP_CHECK      = 3'd3,
        OP_REQUEST    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_SAFE    = 3'd0,
        ST_EXCEEDS = 3'd1,
        ST_WAIT    = 3'd2,
        ST_NOTHING = 3'd3,
        ST_UNSAFE  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_PROCESSES = 1'b0,
        CFG_NUM_RESOURCES = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic need_gt_work;
        logic req_gt_need;
        logic req_gt_avail;
        logic avail_gt_req;
    } t_unit_flags;

endpackage

FILE: design/bsr_req_if.sv
// Input request channel: valid/ready handshake with operation payload.
// Depends on bsr_pkg.
interface bsr_req_if import bsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [PROC_W-1:0] process;
    logic [RES_W-1:0]  resource;
    logic [UNIT_W-1:0] value;
    logic [UNIT_W-1:0] request_0;
    logic [UNIT_W-1:0] request_1;
    logic [UNIT_W-1:0] request_2;
    logic [UNIT_W-1:0] request_3;

    modport source (
        output valid, operation, process, resource, value,
               request_0, request_1, request_2, request_3,
        input  ready
    );
    modport sink (
        input  valid, operation, process, resource, value,
               request_0, request_1, request_2, request_3,
        output ready
    );
endinterface

FILE: design/bsr_res_if.sv
// Result channel: valid/ready handshake with status, order entry and last flag.
// Depends on bsr_pkg.
interface bsr_res_if import bsr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    sequence_process;
    logic                last;

    modport source (output valid, status, sequence_process, last, input ready);
    modport sink   (input valid, status, sequence_process, last, output ready);
endinterface

FILE: design/bsr_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on bsr_pkg.
interface bsr_cfg_if import bsr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/bsr_table.sv
// Per-entry table store: generic RAM plus valid bits so unwritten entries read zero.
// Depends on bsr_pkg and bsr_ram.
module bsr_table
    import bsr_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [UNIT_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [UNIT_W-1:0]        o_rdata
);
    logic [DEPTH-1:0]  r_valid;
    logic              r_rd_valid;
    logic [UNIT_W-1:0] ram_q;

    bsr_ram #(
        .WIDTH (UNIT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? ram_q : '0;
endmodule

FILE: design/bsr_unit.sv
// Shared compare/add unit: need versus work, request screening tests, work sum.
// Depends on bsr_pkg.
module bsr_unit
    import bsr_pkg::*;
#(
    parameter int WORK_W = 12
) (
    input  logic [UNIT_W-1:0] i_claim,
    input  logic [UNIT_W-1:0] i_alloc,
    input  logic [WORK_W-1:0] i_work,
    input  logic [UNIT_W-1:0] i_req,
    input  logic [UNIT_W-1:0] i_avail,
    output logic [WORK_W-1:0] o_sum,
    output t_unit_flags       o_flags
);
    logic signed [UNIT_W:0]   need;
    logic signed [WORK_W:0]   need_x;

    always_comb begin
        need   = $signed({1'b0, i_claim}) - $signed({1'b0, i_alloc});
        need_x = (WORK_W + 1)'(need);
        o_flags.need_gt_work = need_x > $signed({1'b0, i_work});
        o_flags.req_gt_need  = $signed({1'b0, i_req}) > need;
        o_flags.req_gt_avail = i_req > i_avail;
        o_flags.avail_gt_req = i_avail > i_req;
        o_sum = i_work + WORK_W'(i_alloc);
    end
endmodule

FILE: design/bankers_safety_and_request_top.sv
// Banker's algorithm block: tables, sequencer and result register.
// Depends on bsr_pkg, the channel interfaces, bsr_table, bsr_unit and the assert header.
//
// Usage:
//   i_cfg : register writes (processes in use, resource types in use), always ready.
//   i_req : one request per operation; ready only while the sequencer is idle.
//   o_res : result requests; a check or granted request returns the safe order,
//           one process per request, last set on the final one; any other outcome
//           returns one request with its status and last set. Loads return nothing.
// Timing:
//   Loads are written when accepted in the idle state. The safety scan reads one
//   (process, type) element per cycle through the shared unit and enters a drain
//   state after each pass, with passes <= np + 1. A request first screens each type
//   (read, then evaluate), then applies it and, if unsafe, rolls it back per type.
//   Results then leave at one per cycle while the receiver takes them.
// Reset: tables, available vector and output valid clear; processes 8, types 4.
// Stall: the result register holds while o_res.ready is low; the sequencer waits.
`include "bankers_safety_and_request_top_assert.svh"
module bankers_safety_and_request_top
    import bsr_pkg::*;
#(
    parameter int PROCESSES = 8,
    parameter int RESOURCES = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsr_cfg_if.sink   i_cfg,
    bsr_req_if.sink   i_req,
    bsr_res_if.source o_res
);
    localparam int MAX_ACTIVE = (PROCESSES < 8) ? PROCESSES : 8;
    localparam int DEPTH      = PROCESSES * RESOURCES;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int OW         = $clog2(MAX_ACTIVE);
    localparam int NPW        = $clog2(MAX_ACTIVE + 1);
    localparam int RW         = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int NRW        = $clog2(RESOURCES + 1);
    localparam int WW         = UNIT_W + $clog2(MAX_ACTIVE + 1);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b0000000001,
        S_SCR_RD     = 10'b0000000010,
        S_SCR_EV     = 10'b0000000100,
        S_APPLY      = 10'b0000001000,
        S_SCAN_INIT  = 10'b0000010000,
        S_SCAN       = 10'b0000100000,
        S_DRAIN      = 10'b0001000000,
        S_ROLLBACK   = 10'b0010000000,
        S_EMIT_ORDER = 10'b0100000000,
        S_EMIT_ONE   = 10'b1000000000
    } t_state;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] p,
                                                  input logic [ADDR_W-1:0] r);
        return p * ADDR_W'(RESOURCES) + r;
    endfunction

    // control registers
    t_state                r_state, n_state;
    logic [NUM_PROC_W-1:0] r_num_proc;
    logic [NUM_RES_W-1:0]  r_num_res;
    logic [UNIT_W-1:0]     r_avail [RESOURCES];
    logic [UNIT_W-1:0]     n_avail [RESOURCES];
    logic [MAX_ACTIVE-1:0] r_done, n_done;
    logic [NPW-1:0]        r_count, n_count;
    logic                  r_progress, n_progress;
    logic                  r_ev, n_ev;
    logic                  r_out_valid, n_out_valid;
    logic [OW-1:0]         r_i, n_i;
    logic [RW-1:0]         r_j, n_j;
    logic [OW-1:0]         r_k, n_k;

    // payload registers
    logic [OP_W-1:0]       r_op;
    logic [PROC_W-1:0]     r_proc;
    logic [UNIT_W-1:0]     r_req   [RESOURCES];
    logic [UNIT_W-1:0]     in_req  [RESOURCES];
    logic [UNIT_W-1:0]     r_saved [RESOURCES];
    logic [UNIT_W-1:0]     n_saved [RESOURCES];
    logic [WW-1:0]         r_work  [RESOURCES];
    logic [WW-1:0]         n_work  [RESOURCES];
    logic [WW-1:0]         r_temp  [RESOURCES];
    logic [WW-1:0]         n_temp  [RESOURCES];
    logic [SEQ_W-1:0]      r_order [MAX_ACTIVE];
    logic [SEQ_W-1:0]      n_order [MAX_ACTIVE];
    logic [OW-1:0]         r_ev_i, n_ev_i;
    logic [RW-1:0]         r_ev_j, n_ev_j;
    logic                  r_fits, n_fits;
    logic                  r_keeps, n_keeps;
    t_status               r_status, n_status;
    t_status               r_out_status, n_out_status;
    logic [SEQ_W-1:0]      r_out_seq, n_out_seq;
    logic                  r_out_last, n_out_last;

    // datapath signals
    logic                  in_acc;
    logic                  out_free;
    logic [NPW-1:0]        np_eff;
    logic [NRW-1:0]        nr_eff;
    logic                  j_last, i_last, k_last;
    logic                  ev_fits, ev_last, commit;
    logic [NPW-1:0]        cnt_next;
    logic                  prog_next;
    logic [UNIT_W-1:0]     claim_q, alloc_q;
    logic [UNIT_W-1:0]     u_alloc;
    logic [WW-1:0]         u_work;
    logic [WW-1:0]         u_sum;
    t_unit_flags           u_flags;
    logic                  alloc_we, claim_we;
    logic [ADDR_W-1:0]     alloc_waddr, claim_waddr, rd_addr;
    logic [UNIT_W-1:0]     alloc_wdata;
    logic                  load_ok;

    assign in_acc        = i_req.valid & i_req.ready;
    assign out_free      = !r_out_valid || o_res.ready;
    assign i_req.ready   = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.sequence_process = r_out_seq;
    assign o_res.last    = r_out_last;

    always_comb begin
        if (r_num_proc == '0) begin
            np_eff = NPW'(1);
        end else if (int'(r_num_proc) > MAX_ACTIVE) begin
            np_eff = NPW'(MAX_ACTIVE);
        end else begin
            np_eff = NPW'(r_num_proc);
        end
        if (r_num_res == '0) begin
            nr_eff = NRW'(1);
        end else if (int'(r_num_res) > RESOURCES) begin
            nr_eff = NRW'(RESOURCES);
        end else begin
            nr_eff = NRW'(r_num_res);
        end
    end

    always_comb begin
        for (int k = 0; k < RESOURCES; k++) begin
            unique case (k)
                0:       in_req[k] = i_req.request_0;
                1:       in_req[k] = i_req.request_1;
                2:       in_req[k] = i_req.request_2;
                3:       in_req[k] = i_req.request_3;
                default: in_req[k] = '0;
            endcase
        end
    end

    assign j_last = (NRW'(r_j) + NRW'(1)) == nr_eff;
    assign i_last = (NPW'(r_i) + NPW'(1)) == np_eff;
    assign k_last = (NPW'(r_k) + NPW'(1)) == np_eff;

    // shared unit operand select
    assign u_work  = (r_state == S_APPLY) ? WW'(r_req[r_j]) : r_work[r_ev_j];
    assign u_alloc = (r_state == S_APPLY) ? r_saved[r_j] : alloc_q;

    bsr_unit #(
        .WORK_W (WW)
    ) u_unit (
        .i_claim (claim_q),
        .i_alloc (u_alloc),
        .i_work  (u_work),
        .i_req   (r_req[r_j]),
        .i_avail (r_avail[r_j]),
        .o_sum   (u_sum),
        .o_flags (u_flags)
    );

    assign ev_fits   = ((r_ev_j == '0) ? 1'b1 : r_fits) & !u_flags.need_gt_work;
    assign ev_last   = (NRW'(r_ev_j) + NRW'(1)) == nr_eff;
    assign commit    = r_ev & ev_last & ev_fits & !r_done[r_ev_i];
    assign cnt_next  = r_count + NPW'(commit);
    assign prog_next = r_progress | commit;

    // table ports
    always_comb begin
        load_ok     = (int'(i_req.process) < PROCESSES) && (int'(i_req.resource) < RESOURCES);
        claim_we    = in_acc && (i_req.operation == OP_LOAD_CLAIM) && load_ok;
        claim_waddr = addr_of(ADDR_W'(i_req.process), ADDR_W'(i_req.resource));
        alloc_we    = 1'b0;
        alloc_waddr = claim_waddr;
        alloc_wdata = i_req.value;
        if (in_acc && (i_req.operation == OP_LOAD_ALLOC) && load_ok) begin
            alloc_we = 1'b1;
        end else if (r_state == S_APPLY) begin
            alloc_we    = 1'b1;
            alloc_waddr = addr_of(ADDR_W'(r_proc), ADDR_W'(r_j));
            alloc_wdata = u_sum[UNIT_W-1:0];
        end else if (r_state == S_ROLLBACK) begin
            alloc_we    = 1'b1;
            alloc_waddr = addr_of(ADDR_W'(r_proc), ADDR_W'(r_j));
            alloc_wdata = r_saved[r_j];
        end
        if (r_state == S_SCR_RD) begin
            rd_addr = addr_of(ADDR_W'(r_proc), ADDR_W'(r_j));
        end else begin
            rd_addr = addr_of(ADDR_W'(r_i), ADDR_W'(r_j));
        end
    end

    bsr_table #(
        .DEPTH (DEPTH)
    ) u_alloc_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (alloc_we),
        .i_waddr (alloc_waddr),
        .i_wdata (alloc_wdata),
        .i_raddr (rd_addr),
        .o_rdata (alloc_q)
    );

    bsr_table #(
        .DEPTH (DEPTH)
    ) u_claim_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (claim_we),
        .i_waddr (claim_waddr),
        .i_wdata (i_req.value),
        .i_raddr (rd_addr),
        .o_rdata (claim_q)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_avail      = r_avail;
        n_done       = r_done;
        n_count      = r_count;
        n_progress   = r_progress;
        n_ev         = (r_state == S_SCAN);
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_saved      = r_saved;
        n_work       = r_work;
        n_temp       = r_temp;
        n_order      = r_order;
        n_ev_i       = r_i;
        n_ev_j       = r_j;
        n_fits       = r_fits;
        n_keeps      = r_keeps;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_seq    = r_out_seq;
        n_out_last   = r_out_last;

        if (r_ev) begin
            n_temp[r_ev_j] = u_sum;
            n_fits         = ev_fits;
            if (commit) begin
                for (int k = 0; k < RESOURCES; k++) begin
                    n_work[k] = (RW'(k) == r_ev_j) ? u_sum : r_temp[k];
                end
                n_done[r_ev_i]               = 1'b1;
                n_order[r_count[OW-1:0]]     = SEQ_W'(r_ev_i);
                n_count                      = cnt_next;
                n_progress                   = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_req.operation))
                        OP_LOAD_AVAIL: begin
                            for (int k = 0; k < RESOURCES; k++) begin
                                if (k == int'(i_req.resource)) begin
                                    n_avail[k] = i_req.value;
                                end
                            end
                        end
                        OP_CHECK: begin
                            n_state = S_SCAN_INIT;
                        end
                        OP_REQUEST: begin
                            if (int'(i_req.process) >= int'(np_eff)) begin
                                n_status = ST_EXCEEDS;
                                n_state  = S_EMIT_ONE;
                            end else begin
                                n_j     = '0;
                                n_keeps = 1'b0;
                                n_state = S_SCR_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCR_RD: begin
                n_state = S_SCR_EV;
            end
            S_SCR_EV: begin
                n_saved[r_j] = alloc_q;
                if (u_flags.req_gt_need) begin
                    n_status = ST_EXCEEDS;
                    n_state  = S_EMIT_ONE;
                end else if (u_flags.req_gt_avail) begin
                    n_status = ST_WAIT;
                    n_state  = S_EMIT_ONE;
                end else begin
                    n_keeps = r_keeps | u_flags.avail_gt_req;
                    if (j_last) begin
                        n_j = '0;
                        if (!n_keeps) begin
                            n_status = ST_NOTHING;
                            n_state  = S_EMIT_ONE;
                        end else begin
                            n_state = S_APPLY;
                        end
                    end else begin
                        n_j     = r_j + RW'(1);
                        n_state = S_SCR_RD;
                    end
                end
            end
            S_APPLY: begin
                if (j_last) begin
                    for (int k = 0; k < RESOURCES; k++) begin
                        if (k < int'(nr_eff)) begin
                            n_avail[k] = r_avail[k] - r_req[k];
                        end
                    end
                    n_state = S_SCAN_INIT;
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            S_SCAN_INIT: begin
                for (int k = 0; k < RESOURCES; k++) begin
                    n_work[k] = WW'(r_avail[k]);
                end
                n_done     = '0;
                n_count    = '0;
                n_progress = 1'b0;
                n_i        = '0;
                n_j        = '0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_i = r_i + OW'(1);
                    end
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            S_DRAIN: begin
                if (cnt_next == np_eff) begin
                    n_k     = '0;
                    n_state = S_EMIT_ORDER;
                end else if (prog_next) begin
                    n_i        = '0;
                    n_j        = '0;
                    n_progress = 1'b0;
                    n_state    = S_SCAN;
                end else if (r_op == OP_REQUEST) begin
                    n_j     = '0;
                    n_state = S_ROLLBACK;
                end else begin
                    n_status = ST_UNSAFE;
                    n_state  = S_EMIT_ONE;
                end
            end
            S_ROLLBACK: begin
                if (j_last) begin
                    for (int k = 0; k < RESOURCES; k++) begin
                        if (k < int'(nr_eff)) begin
                            n_avail[k] = r_avail[k] + r_req[k];
                        end
                    end
                    n_status = ST_UNSAFE;
                    n_state  = S_EMIT_ONE;
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            S_EMIT_ORDER: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_SAFE;
                    n_out_seq    = r_order[r_k];
                    n_out_last   = k_last;
                    if (k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + OW'(1);
                    end
                end
            end
            S_EMIT_ONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_seq    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_proc  <= NUM_PROC_W'(8);
            r_num_res   <= NUM_RES_W'(4);
            r_avail     <= '{default: '0};
            r_done      <= '0;
            r_count     <= '0;
            r_progress  <= 1'b0;
            r_ev        <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_avail     <= n_avail;
            r_done      <= n_done;
            r_count     <= n_count;
            r_progress  <= n_progress;
            r_ev        <= n_ev;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            if (i_cfg.valid) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    CFG_NUM_PROCESSES: r_num_proc <= i_cfg.data;
                    CFG_NUM_RESOURCES: r_num_res  <= i_cfg.data[NUM_RES_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_req.operation;
            r_proc <= i_req.process;
            r_req  <= in_req;
        end
        r_saved      <= n_saved;
        r_work       <= n_work;
        r_temp       <= n_temp;
        r_order      <= n_order;
        r_ev_i       <= n_ev_i;
        r_ev_j       <= n_ev_j;
        r_fits       <= n_fits;
        r_keeps      <= n_keeps;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_seq    <= n_out_seq;
        r_out_last   <= n_out_last;
    end

    `BSR_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset did not idle the sequencer")
    `BSR_ASSERT(a_done_count, (r_state == S_SCAN || r_state == S_DRAIN) |-> ($countones(r_done) == r_count), "finished set and order count disagree")
    `BSR_ASSERT(a_order_full, (r_state == S_EMIT_ORDER) |-> (r_count == np_eff), "safe order emitted before it is complete")
    `BSR_ASSERT(a_ev_from_scan, r_ev |-> $past(r_state == S_SCAN), "scan evaluation without a table read")
    `BSR_ASSERT(a_rollback_req, (r_state == S_ROLLBACK) |-> (r_op == OP_REQUEST), "rollback outside a request")

endmodule
